>>> src/sgti_pkg.sv
// ============================================================================
// sgti_pkg
// Shared types and constants for the UV-sphere triangle index generator.
// ============================================================================
`default_nettype none

package sgti_pkg;

    // Parameter defaults
    localparam int DEF_MAX_SLICES = 256;
    localparam int DEF_MAX_STACKS = 256;
    localparam int DEF_INDEX_BITS = 16;

    // Fixed field widths
    localparam int CFG_W      = 9;
    localparam int VERTEX_W   = 16;
    localparam int REGION_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] SLICE_COUNT_RESET = 9'd32;
    localparam logic [CFG_W-1:0] STACK_COUNT_RESET = 9'd24;

    // Register index, taken from paddr[2]
    localparam logic REG_SLICE_COUNT = 1'b0;
    localparam logic REG_STACK_COUNT = 1'b1;

    // Region codes on the result word
    localparam logic [REGION_W-1:0] REGION_TOP = 2'd0;
    localparam logic [REGION_W-1:0] REGION_MID = 2'd1;
    localparam logic [REGION_W-1:0] REGION_BOT = 2'd2;

    typedef enum logic [2:0] {
        PH_TOP = 3'b001,
        PH_MID = 3'b010,
        PH_BOT = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] slice_count;
        logic [CFG_W-1:0] stack_count;
        logic             restart;      // pulses on any register write
    } cfg_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_first;
        logic [VERTEX_W-1:0] vertex_second;
        logic [VERTEX_W-1:0] vertex_third;
        logic [REGION_W-1:0] region;
        logic                last_triangle;
    } tri_t;

endpackage

`default_nettype wire

>>> src/sgti_if.sv
// ============================================================================
// sgti_if
// Valid/ready channels: request words in, triangle words out.
// ============================================================================
`default_nettype none

interface sgti_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface sgti_tri_if;
    logic                           valid;
    logic                           ready;
    logic [sgti_pkg::VERTEX_W-1:0]  vertex_first;
    logic [sgti_pkg::VERTEX_W-1:0]  vertex_second;
    logic [sgti_pkg::VERTEX_W-1:0]  vertex_third;
    logic [sgti_pkg::REGION_W-1:0]  region;
    logic                           last_triangle;

    modport source (output valid, output vertex_first, output vertex_second,
                    output vertex_third, output region, output last_triangle,
                    input ready);
    modport sink   (input valid, input vertex_first, input vertex_second,
                    input vertex_third, input region, input last_triangle,
                    output ready);
endinterface

`default_nettype wire

>>> src/sgti_apb_regs.sv
// ============================================================================
// sgti_apb_regs
// APB register file: slice_count at 0x0, stack_count at 0x4.
// ============================================================================
`default_nettype none

module sgti_apb_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sgti_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sgti_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [sgti_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output sgti_pkg::cfg_t                         cfg
);

    logic [sgti_pkg::CFG_W-1:0] slice_count_reg;
    logic [sgti_pkg::CFG_W-1:0] stack_count_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= sgti_pkg::SLICE_COUNT_RESET;
            stack_count_reg <= sgti_pkg::STACK_COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                sgti_pkg::REG_SLICE_COUNT: slice_count_reg <= pwdata[sgti_pkg::CFG_W-1:0];
                sgti_pkg::REG_STACK_COUNT: stack_count_reg <= pwdata[sgti_pkg::CFG_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sgti_pkg::REG_SLICE_COUNT: prdata = sgti_pkg::APB_DATA_W'(slice_count_reg);
            sgti_pkg::REG_STACK_COUNT: prdata = sgti_pkg::APB_DATA_W'(stack_count_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.slice_count = slice_count_reg;
    assign cfg.stack_count = stack_count_reg;
    assign cfg.restart     = wr_en;

endmodule

`default_nettype wire

>>> src/sgti_walker.sv
// ============================================================================
// sgti_walker
// Mesh walk state and the combinational triangle/next-state logic.
// ============================================================================
`default_nettype none

module sgti_walker #(
    parameter int MAX_SLICES = sgti_pkg::DEF_MAX_SLICES,
    parameter int MAX_STACKS = sgti_pkg::DEF_MAX_STACKS,
    parameter int INDEX_BITS = sgti_pkg::DEF_INDEX_BITS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sgti_pkg::cfg_t cfg,
    input  wire logic           step,
    input  wire logic           restart,
    output sgti_pkg::tri_t      result
);

    localparam int SW = $clog2(MAX_SLICES + 1);   // effective slice count
    localparam int KW = $clog2(MAX_SLICES);       // slice position
    localparam int TW = $clog2(MAX_STACKS + 1);   // effective stack count
    localparam int BW = $clog2(MAX_STACKS);       // band position
    localparam int IW = INDEX_BITS;

    sgti_pkg::phase_t phase_reg, phase_cur, phase_next;
    logic [KW-1:0]    pos_reg, pos_cur, pos_next;
    logic [BW-1:0]    band_reg, band_cur, band_next;
    logic [IW-1:0]    upper_reg, upper_cur, upper_next;
    logic [IW-1:0]    lower_reg, lower_cur, lower_next;
    logic             half_reg, half_cur, half_next;

    logic [SW-1:0]    s_eff;
    logic [TW-1:0]    t_eff;
    logic [IW-1:0]    first_ring;
    logic [KW-1:0]    k;
    logic [KW-1:0]    n;
    logic [SW-1:0]    k_inc;
    logic             wrap;
    logic [TW-1:0]    band_inc;
    logic [IW-1:0]    kx, nx, va, vb, vc;

    // Clamp the registers to their legal ranges
    always_comb
    begin
        if (cfg.slice_count < sgti_pkg::CFG_W'(3))
            s_eff = SW'(3);
        else if (32'(cfg.slice_count) > 32'(MAX_SLICES))
            s_eff = SW'(MAX_SLICES);
        else
            s_eff = SW'(cfg.slice_count);

        if (cfg.stack_count < sgti_pkg::CFG_W'(2))
            t_eff = TW'(2);
        else if (32'(cfg.stack_count) > 32'(MAX_STACKS))
            t_eff = TW'(MAX_STACKS);
        else
            t_eff = TW'(cfg.stack_count);
    end

    assign first_ring = IW'(1) + IW'(s_eff);

    // Restart request overrides the stored walk position
    always_comb
    begin
        if (restart)
        begin
            phase_cur = sgti_pkg::PH_TOP;
            pos_cur   = '0;
            band_cur  = '0;
            upper_cur = IW'(1);
            lower_cur = first_ring;
            half_cur  = 1'b0;
        end
        else
        begin
            phase_cur = phase_reg;
            pos_cur   = pos_reg;
            band_cur  = band_reg;
            upper_cur = upper_reg;
            lower_cur = lower_reg;
            half_cur  = half_reg;
        end
    end

    always_comb
    begin
        if (SW'(pos_cur) >= s_eff)
            k = KW'(s_eff - SW'(1));
        else
            k = pos_cur;
        k_inc    = SW'(k) + SW'(1);
        wrap     = (k_inc == s_eff);
        n        = wrap ? '0 : KW'(k_inc);
        kx       = IW'(k);
        nx       = IW'(n);
        band_inc = TW'(band_cur) + TW'(1);
    end

    always_comb
    begin
        phase_next = phase_cur;
        pos_next   = pos_cur;
        band_next  = band_cur;
        upper_next = upper_cur;
        lower_next = lower_cur;
        half_next  = half_cur;
        result.last_triangle = 1'b0;

        unique case (phase_cur)
            sgti_pkg::PH_MID:
            begin
                result.region = sgti_pkg::REGION_MID;
                if (!half_cur)
                begin
                    va        = lower_cur + kx;
                    vb        = lower_cur + nx;
                    vc        = upper_cur + nx;
                    half_next = 1'b1;
                end
                else
                begin
                    va        = lower_cur + kx;
                    vb        = upper_cur + nx;
                    vc        = upper_cur + kx;
                    half_next = 1'b0;
                    if (wrap)
                    begin
                        pos_next   = '0;
                        band_next  = BW'(band_inc);
                        upper_next = upper_cur + IW'(s_eff);
                        lower_next = lower_cur + IW'(s_eff);
                        if (band_inc >= t_eff - TW'(2))
                            phase_next = sgti_pkg::PH_BOT;
                    end
                    else
                    begin
                        pos_next = n;
                    end
                end
            end
            sgti_pkg::PH_BOT:
            begin
                result.region = sgti_pkg::REGION_BOT;
                va = lower_cur;
                vb = lower_cur - IW'(1) - kx;
                vc = lower_cur - IW'(1) - nx;
                if (wrap)
                begin
                    result.last_triangle = 1'b1;
                    phase_next = sgti_pkg::PH_TOP;
                    pos_next   = '0;
                    band_next  = '0;
                    upper_next = IW'(1);
                    lower_next = first_ring;
                    half_next  = 1'b0;
                end
                else
                begin
                    pos_next = n;
                end
            end
            default:
            begin
                // top fan; unused phase codes fall here as well
                result.region = sgti_pkg::REGION_TOP;
                va = '0;
                vb = IW'(1) + kx;
                vc = IW'(1) + nx;
                if (wrap)
                begin
                    pos_next   = '0;
                    band_next  = '0;
                    half_next  = 1'b0;
                    upper_next = IW'(1);
                    lower_next = first_ring;
                    phase_next = (t_eff > TW'(2)) ? sgti_pkg::PH_MID : sgti_pkg::PH_BOT;
                end
                else
                begin
                    pos_next = n;
                end
            end
        endcase

        result.vertex_first  = sgti_pkg::VERTEX_W'(va);
        result.vertex_second = sgti_pkg::VERTEX_W'(vb);
        result.vertex_third  = sgti_pkg::VERTEX_W'(vc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sgti_pkg::PH_TOP;
            pos_reg   <= '0;
            band_reg  <= '0;
            upper_reg <= IW'(1);
            lower_reg <= IW'(1) + IW'(sgti_pkg::SLICE_COUNT_RESET);
            half_reg  <= 1'b0;
        end
        else if (cfg.restart)
        begin
            phase_reg <= sgti_pkg::PH_TOP;
            pos_reg   <= '0;
            band_reg  <= '0;
            upper_reg <= IW'(1);
            lower_reg <= first_ring;
            half_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            band_reg  <= band_next;
            upper_reg <= upper_next;
            lower_reg <= lower_next;
            half_reg  <= half_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sphere_grid_triangle_index_generator_core.sv
// Pipeline: a request word goes into the input register; when the result register
//   is free the walker steps and its triangle word is loaded into the output register.
// Throughput: one triangle per cycle unless the output stalls; the walker updates its
//   counters and ring offsets combinationally, so every such cycle can take a new request.
// Reset: rst_n clears both pipeline valids and puts the walk at the first
//   top-fan triangle with slice_count 32 and stack_count 24.
// ============================================================================
// sphere_grid_triangle_index_generator_core
// UV-sphere triangle index generator: one triangle word per request word.
// ============================================================================
`default_nettype none

module sphere_grid_triangle_index_generator_core #(
    parameter int MAX_SLICES = sgti_pkg::DEF_MAX_SLICES,
    parameter int MAX_STACKS = sgti_pkg::DEF_MAX_STACKS,
    parameter int INDEX_BITS = sgti_pkg::DEF_INDEX_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [sgti_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [sgti_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [sgti_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // channels
    sgti_req_if.sink                               request,
    sgti_tri_if.source                             triangle
);

    sgti_pkg::cfg_t cfg;
    sgti_pkg::tri_t walk_result;
    sgti_pkg::tri_t out_tri_reg;

    // input stage
    logic s1_valid_reg, s1_valid_next;
    logic s1_restart_reg;
    // output stage
    logic out_valid_reg, out_valid_next;

    logic out_free;     // result register can take a word this cycle
    logic step;         // walker produces a triangle this cycle
    logic req_take;

    sgti_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgti_walker #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_STACKS (MAX_STACKS),
        .INDEX_BITS (INDEX_BITS)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (step),
        .restart (s1_restart_reg),
        .result  (walk_result)
    );

    // Handshake: the input stage drains whenever the result register is empty
    // or being taken, so request.ready stays high through back-to-back traffic.
    assign out_free      = !out_valid_reg || triangle.ready;
    assign step          = s1_valid_reg && out_free;
    assign request.ready = !s1_valid_reg || step;
    assign req_take      = request.valid && request.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_take)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (triangle.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_take)
            s1_restart_reg <= request.restart;
        if (step)
            out_tri_reg <= walk_result;
    end

    assign triangle.valid         = out_valid_reg;
    assign triangle.vertex_first  = out_tri_reg.vertex_first;
    assign triangle.vertex_second = out_tri_reg.vertex_second;
    assign triangle.vertex_third  = out_tri_reg.vertex_third;
    assign triangle.region        = out_tri_reg.region;
    assign triangle.last_triangle = out_tri_reg.last_triangle;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Only a bottom-fan triangle can close the mesh.
    a_last_is_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        (triangle.valid && triangle.last_triangle) |->
            (triangle.region == sgti_pkg::REGION_BOT))
        else $error("last_triangle outside bottom fan");

    // Top fan always starts at the pole vertex.
    a_top_uses_pole: assert property (@(posedge clk) disable iff (!rst_n)
        (triangle.valid && triangle.region == sgti_pkg::REGION_TOP) |->
            (triangle.vertex_first == '0))
        else $error("top fan triangle not anchored at pole");

    // A word held in the input stage behind a stalled output is not lost.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !triangle.ready) |=>
            (s1_valid_reg && $stable(s1_restart_reg)))
        else $error("input stage dropped a word during stall");

    // The walker only steps when the result register accepts its word.
    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("walker stepped without loading a result");

endmodule

`default_nettype wire

>>> tb/sphere_walk_tracker_pkg.sv
// ----------------------------------------------------------------------------
// sphere_walk_tracker_pkg
// Triangle-walk predictor and result store for the sphere index generator.
// ----------------------------------------------------------------------------
package sphere_walk_tracker_pkg;

    import sgti_pkg::*;

    class sphere_walk_tracker;

        // register copies, as written
        logic [CFG_W-1:0] slice_reg;
        logic [CFG_W-1:0] stack_reg;

        // walk state
        phase_t walk_phase;
        int     slice_pos;
        int     band_pos;
        int     upper_ring;
        int     lower_ring;
        bit     second_half;

        tri_t   pending_triangles[$];

        int     mismatches;
        int     words_taken;
        int     restarts_taken;
        int     writes_taken;
        int     triangles_seen;
        int     meshes_closed;

        function new();
            slice_reg      = SLICE_COUNT_RESET;
            stack_reg      = STACK_COUNT_RESET;
            mismatches     = 0;
            words_taken    = 0;
            restarts_taken = 0;
            writes_taken   = 0;
            triangles_seen = 0;
            meshes_closed  = 0;
            restart_walk();
        endfunction

        // registers saturate when used
        function int eff_slices();
            int s;
            s = slice_reg;
            if (s < 3) s = 3;
            if (s > DEF_MAX_SLICES) s = DEF_MAX_SLICES;
            return s;
        endfunction

        function int eff_stacks();
            int t;
            t = stack_reg;
            if (t < 2) t = 2;
            if (t > DEF_MAX_STACKS) t = DEF_MAX_STACKS;
            return t;
        endfunction

        function int mesh_length();
            return 2 * eff_slices() * (eff_stacks() - 1);
        endfunction

        function int pending();
            return pending_triangles.size();
        endfunction

        function void restart_walk();
            walk_phase  = PH_TOP;
            slice_pos   = 0;
            band_pos    = 0;
            upper_ring  = 1;
            lower_ring  = (1 + eff_slices()) & 16'hFFFF;
            second_half = 1'b0;
        endfunction

        // any write restarts the walk
        function void load_register(logic sel, logic [CFG_W-1:0] value);
            if (sel == REG_SLICE_COUNT)
                slice_reg = value;
            else
                stack_reg = value;
            writes_taken++;
            restart_walk();
        endfunction

        function tri_t next_triangle(logic restart_bit);
            int   s;
            int   t;
            int   k;
            int   n;
            tri_t word;
            s = eff_slices();
            t = eff_stacks();
            if (restart_bit)
                restart_walk();
            k = (slice_pos >= s) ? s - 1 : slice_pos;
            n = (k + 1 == s) ? 0 : k + 1;
            word.last_triangle = 1'b0;
            case (walk_phase)
                PH_MID:
                begin
                    word.region       = REGION_MID;
                    word.vertex_first = 16'(lower_ring + k);
                    if (!second_half)
                    begin
                        word.vertex_second = 16'(lower_ring + n);
                        word.vertex_third  = 16'(upper_ring + n);
                        second_half        = 1'b1;
                    end
                    else
                    begin
                        word.vertex_second = 16'(upper_ring + n);
                        word.vertex_third  = 16'(upper_ring + k);
                        second_half        = 1'b0;
                        if (n == 0)
                        begin
                            // ring wrap: step both rings down one band
                            slice_pos  = 0;
                            band_pos++;
                            upper_ring = (upper_ring + s) & 16'hFFFF;
                            lower_ring = (lower_ring + s) & 16'hFFFF;
                            if (band_pos >= t - 2)
                                walk_phase = PH_BOT;
                        end
                        else
                            slice_pos = n;
                    end
                end
                PH_BOT:
                begin
                    word.region        = REGION_BOT;
                    word.vertex_first  = 16'(lower_ring);
                    word.vertex_second = 16'(lower_ring - 1 - k);
                    word.vertex_third  = 16'(lower_ring - 1 - n);
                    if (n == 0)
                    begin
                        word.last_triangle = 1'b1;
                        restart_walk();
                    end
                    else
                        slice_pos = n;
                end
                default:
                begin
                    word.region        = REGION_TOP;
                    word.vertex_first  = '0;
                    word.vertex_second = 16'(1 + k);
                    word.vertex_third  = 16'(1 + n);
                    if (n == 0)
                    begin
                        slice_pos   = 0;
                        band_pos    = 0;
                        second_half = 1'b0;
                        upper_ring  = 1;
                        lower_ring  = (1 + s) & 16'hFFFF;
                        walk_phase  = (t > 2) ? PH_MID : PH_BOT;
                    end
                    else
                        slice_pos = n;
                end
            endcase
            return word;
        endfunction

        function void note_request(logic restart_bit);
            words_taken++;
            if (restart_bit)
                restarts_taken++;
            pending_triangles.insert(pending_triangles.size(), next_triangle(restart_bit));
        endfunction

        function void check_field(string name, logic [VERTEX_W-1:0] want,
                                  logic [VERTEX_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_triangle(tri_t seen);
            tri_t want;
            triangles_seen++;
            if (pending_triangles.size() == 0)
            begin
                $error("triangle word with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_triangles.pop_front();
            check_field("vertex_first", want.vertex_first, seen.vertex_first);
            check_field("vertex_second", want.vertex_second, seen.vertex_second);
            check_field("vertex_third", want.vertex_third, seen.vertex_third);
            check_field("region", 16'(want.region), 16'(seen.region));
            check_field("last_triangle", 16'(want.last_triangle),
                        16'(seen.last_triangle));
            if (want.last_triangle)
                meshes_closed++;
        endfunction

    endclass

endpackage

>>> tb/sphere_grid_triangle_index_generator_core_tb.sv
// ----------------------------------------------------------------------------
// sphere_grid_triangle_index_generator_core_tb
// Self-checking bench: request words in, every triangle word predicted and
// compared field by field, across many slice/stack settings and idle mixes.
// ----------------------------------------------------------------------------
module sphere_grid_triangle_index_generator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sgti_pkg::*;
    import sphere_walk_tracker_pkg::*;

    // stop sending random words once this many have gone in
    localparam int RANDOM_WORDS   = 1050;
    // core is two stages deep; the settle wait covers any stray word
    localparam int SETTLE_CYCLES  = 4;
    // cap on words per setting so huge meshes do not eat the budget
    localparam int BURST_CAP      = 120;
    localparam int N_FIXED        = 6;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // idle mix, percent of cycles
    int gap_pct;
    int stall_pct;

    sphere_walk_tracker walk;

    sgti_req_if request_bus();
    sgti_tri_if triangle_bus();

    sphere_grid_triangle_index_generator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .request  (request_bus),
        .triangle (triangle_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the core hangs or drops a word.
    initial
    begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver back-pressure, redrawn every edge.
    always @(posedge clk)
        triangle_bus.ready <= ($urandom_range(99) >= stall_pct);

    // Both handshakes sampled in one process: the request is noted before
    // any result of the same edge is checked.
    always @(posedge clk)
    begin : monitor
        tri_t seen;
        if (rst_n)
        begin
            if (request_bus.valid && request_bus.ready)
                walk.note_request(request_bus.restart);
            if (triangle_bus.valid && triangle_bus.ready)
            begin
                seen.vertex_first  = triangle_bus.vertex_first;
                seen.vertex_second = triangle_bus.vertex_second;
                seen.vertex_third  = triangle_bus.vertex_third;
                seen.region        = triangle_bus.region;
                seen.last_triangle = triangle_bus.last_triangle;
                walk.check_triangle(seen);
            end
        end
    end

    // One request word; random gaps ahead of it per gap_pct.
    // valid stays high on return so back-to-back words need no re-raise.
    task automatic send_request(input logic restart_bit);
        while ($urandom_range(99) < gap_pct)
        begin
            request_bus.valid <= 1'b0;
            @(posedge clk);
        end
        request_bus.valid   <= 1'b1;
        request_bus.restart <= restart_bit;
        @(posedge clk);
        while (!request_bus.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted triangle has come out.
    task automatic drain_triangles();
        request_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (walk.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup, then access; the register takes it at the edge where
    // psel/penable/pwrite/pready are all high. Upper data bits are ignored.
    task automatic write_register(input logic sel, input logic [CFG_W-1:0] value,
                                  input bit junk_upper);
        logic [APB_DATA_W-1:0] data;
        data = junk_upper ? $urandom : '0;
        data[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        walk.load_register(sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly small counts so meshes close often; sometimes below range
    // (saturates up) or far above it (saturates down).
    function automatic logic [CFG_W-1:0] pick_count(int lo, int hi);
        case ($urandom_range(9))
            0:       return CFG_W'($urandom_range(lo - 1));
            1:       return CFG_W'($urandom_range(511, 200));
            2:       return CFG_W'($urandom_range(511));
            default: return CFG_W'($urandom_range(hi, lo));
        endcase
    endfunction

    initial
    begin
        // extreme settings visited first: all-ones, zero, bit 8 alone, etc.
        logic [CFG_W-1:0] fixed_slices [N_FIXED];
        logic [CFG_W-1:0] fixed_stacks [N_FIXED];
        logic [CFG_W-1:0] slices;
        logic [CFG_W-1:0] stacks;
        int               random_sent;
        int               setting;
        int               burst;
        int               which;

        fixed_slices = '{9'd256, 9'd511, 9'd0, 9'd2, 9'd3,   9'd300};
        fixed_stacks = '{9'd256, 9'd2,   9'd1, 9'd511, 9'd2, 9'd257};

        walk                 = new();
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        request_bus.valid    = 1'b0;
        request_bus.restart  = 1'b0;
        triangle_bus.ready   = 1'b0;
        gap_pct              = 0;
        stall_pct            = 0;
        random_sent          = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // reset settings (32 x 24): a few top-fan words, restart mid fan
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain_triangles();

        // smallest mesh (3 x 2): no middle band, top fan straight into the
        // bottom fan, last flag, wrap to top, then a restart
        write_register(REG_SLICE_COUNT, 9'd3, 1'b0);
        write_register(REG_STACK_COUNT, 9'd2, 1'b1);
        repeat (7) send_request(1'b0);
        send_request(1'b1);
        drain_triangles();

        // 3 x 3: one middle band, both quad halves and the ring wrap;
        // a write to one register alone also restarts the walk
        write_register(REG_STACK_COUNT, 9'd3, 1'b0);
        repeat (12) send_request(1'b0);
        drain_triangles();

        // --- random ---
        // Each setting: idle mix rotates, registers rewritten while idle,
        // then a burst of mostly plain advances with rare restarts.
        for (setting = 0; random_sent < RANDOM_WORDS; setting++)
        begin
            case (setting % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 57; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 57; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase

            if (setting < N_FIXED)
            begin
                write_register(REG_SLICE_COUNT, fixed_slices[setting], 1'b1);
                write_register(REG_STACK_COUNT, fixed_stacks[setting], 1'b0);
            end
            else
            begin
                slices = pick_count(3, 8);
                stacks = pick_count(2, 6);
                which  = $urandom_range(2);
                if (which != 1)
                    write_register(REG_SLICE_COUNT, slices, $urandom_range(1));
                if (which != 0)
                    write_register(REG_STACK_COUNT, stacks, $urandom_range(1));
            end

            burst = walk.mesh_length() * $urandom_range(2, 1) + $urandom_range(6);
            if (burst > BURST_CAP)
                burst = BURST_CAP;

            for (int i = 0; i < burst; i++)
            begin
                send_request($urandom_range(99) < 3);
                random_sent++;
                // now and then hold off until the core is empty
                if (setting % 5 == 1 && i == burst / 2)
                    drain_triangles();
            end
            drain_triangles();
        end

        if (walk.pending() != 0)
        begin
            $error("%0d triangle words never arrived", walk.pending());
            walk.mismatches++;
        end

        $display("Covered %0d request words (%0d restarts) over %0d register writes",
                 walk.words_taken, walk.restarts_taken, walk.writes_taken);
        $display("Checked %0d triangle words, %0d full meshes closed, %0d mismatches",
                 walk.triangles_seen, walk.meshes_closed, walk.mismatches);
        if (walk.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
